@@ src/mhs_pkg.sv @@
`default_nettype none

package mhs_pkg;

  localparam int SigW     = 17;
  localparam int BucketW  = 4;
  localparam int RowW     = 10;
  localparam int ColW     = 10;
  localparam int CmdW     = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 4;
  localparam int HwHashes = 3;

  localparam int DefMaxNodes  = 1024;
  localparam int DefNumHashes = 3;

  localparam logic [SigW-1:0] SigEmpty = SigW'(99999);

  localparam logic [CfgDataW-1:0] OffsetReset [HwHashes] = '{4'd1, 4'd2, 4'd5};
  localparam logic [CfgDataW-1:0] SlopeReset  [HwHashes] = '{4'd1, 4'd3, 4'd7};

  typedef enum logic [CmdW-1:0] {
    CmdUpdate = 2'd0,
    CmdRead   = 2'd1,
    CmdClear  = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHash0Offset = 3'd0,
    CfgHash0Slope  = 3'd1,
    CfgHash1Offset = 3'd2,
    CfgHash1Slope  = 3'd3,
    CfgHash2Offset = 3'd4,
    CfgHash2Slope  = 3'd5
  } cfg_idx_e;

endpackage

`default_nettype wire

@@ src/mhs_bucket.sv @@
`default_nettype none

module mhs_bucket (
  input  logic [mhs_pkg::SigW-1:0]    sig_i,
  output logic [mhs_pkg::BucketW-1:0] bucket_o
);
  import mhs_pkg::*;

  localparam logic [15:0] RecipTen = 16'd52429;
  localparam int          RecipSh  = 19;
  localparam int          ProdW    = SigW + 16;
  localparam int          QuoW     = ProdW - RecipSh;

  logic [ProdW-1:0] prod;
  logic [QuoW-1:0]  quo;
  logic [SigW-1:0]  rem;

  // quotient by ten via reciprocal, exact over the full signature range
  assign prod     = ProdW'(sig_i) * ProdW'(RecipTen);
  assign quo      = prod[ProdW-1:RecipSh];
  assign rem      = sig_i - SigW'({quo, 3'b000} + {quo, 1'b0});
  assign bucket_o = rem[BucketW-1:0];

endmodule

`default_nettype wire

@@ src/minhash_signature_engine.sv @@
`default_nettype none

// MinHash signature engine.
// Input: a command transaction is taken at a rising edge where start is high
// and busy is low. cmd_i selects update (lower the column's signatures with
// the hashes of row_index_i when edge_bit_i is set), read (report the
// column's signatures) or clear (forget every column).
// Configuration: cfg_we_i writes cfg_wdata_i into the hash coefficient at
// cfg_index_i at the same edge; write only while no transaction is in flight.
// Output: a read's result passes through the stage-1 registers into the result registers,
// present for one cycle while result_valid_o is high. The receiver cannot stall; there
// is no back pressure on the result side.
// Throughput: one transaction per cycle while busy is low; back-to-back updates to one
// column are forwarded from the write stage, so no bubbles are needed.
// Clear: the column-valid memory is swept one entry per cycle, and busy stays
// high until the sweep has cleared the last entry.
// Reset: coefficients return to their defaults and the same sweep runs before
// the first transaction is taken.
module minhash_signature_engine #(
  parameter int MAX_NODES  = mhs_pkg::DefMaxNodes,
  parameter int NUM_HASHES = mhs_pkg::DefNumHashes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [mhs_pkg::CmdW-1:0]      cmd_i,
  input  logic [mhs_pkg::RowW-1:0]      row_index_i,
  input  logic [mhs_pkg::ColW-1:0]      column_index_i,
  input  logic                          edge_bit_i,
  input  logic                          cfg_we_i,
  input  logic [mhs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mhs_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output logic                          result_valid_o,
  output logic [mhs_pkg::SigW-1:0]      sig_first_o,
  output logic [mhs_pkg::SigW-1:0]      sig_second_o,
  output logic [mhs_pkg::SigW-1:0]      sig_third_o,
  output logic [mhs_pkg::BucketW-1:0]   bucket_first_o,
  output logic [mhs_pkg::BucketW-1:0]   bucket_second_o,
  output logic [mhs_pkg::BucketW-1:0]   bucket_third_o,
  output logic                          column_seen_o
);
  import mhs_pkg::*;

  localparam int AddrW        = $clog2(MAX_NODES);
  localparam int ActiveHashes = (NUM_HASHES < HwHashes) ? NUM_HASHES : HwHashes;
  localparam int LimW         = 17;
  localparam logic [LimW-1:0] NodesLim = LimW'(MAX_NODES);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(MAX_NODES - 1);

  typedef logic [ActiveHashes-1:0][SigW-1:0] sig_row_t;

  logic [CfgDataW-1:0] offset_q [HwHashes];
  logic [CfgDataW-1:0] slope_q  [HwHashes];

  logic                accept;
  logic [AddrW-1:0]    in_addr;
  logic                in_col_ok;
  logic                in_row_ok;

  logic                s1_vld_q;
  cmd_e                s1_cmd_q;
  logic [RowW-1:0]     s1_row_q;
  logic [AddrW-1:0]    s1_addr_q;
  logic                s1_col_ok_q;
  logic                s1_row_ok_q;
  logic                s1_bit_q;

  sig_row_t            sig_mem [MAX_NODES];
  logic                vld_mem [MAX_NODES];
  sig_row_t            rd_sig_q;
  logic                rd_vld_q;

  logic                fwd_q;
  logic                fwd_d;
  sig_row_t            fwd_sig_q;

  logic                clearing_q;
  logic                clearing_d;
  logic [AddrW-1:0]    clr_cnt_q;
  logic [AddrW-1:0]    clr_cnt_d;

  logic                eff_vld;
  sig_row_t            eff_sig;
  sig_row_t            new_sig;
  logic                upd_we;
  logic                rd_go;
  logic                seen;
  logic [SigW-1:0]     out_sig    [HwHashes];
  logic [BucketW-1:0]  out_bucket [HwHashes];

  logic                result_valid_q;
  logic [SigW-1:0]     res_sig_q    [HwHashes];
  logic [BucketW-1:0]  res_bucket_q [HwHashes];
  logic                res_seen_q;

  assign busy      = clearing_q;
  assign accept    = start && !clearing_q;
  assign in_addr   = AddrW'(column_index_i);
  assign in_col_ok = LimW'(column_index_i) < NodesLim;
  assign in_row_ok = LimW'(row_index_i) < NodesLim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HwHashes; k++) begin
        offset_q[k] <= OffsetReset[k];
        slope_q[k]  <= SlopeReset[k];
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgHash0Offset: offset_q[0] <= cfg_wdata_i;
        CfgHash0Slope:  slope_q[0]  <= cfg_wdata_i;
        CfgHash1Offset: offset_q[1] <= cfg_wdata_i;
        CfgHash1Slope:  slope_q[1]  <= cfg_wdata_i;
        CfgHash2Offset: offset_q[2] <= cfg_wdata_i;
        CfgHash2Slope:  slope_q[2]  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    clearing_d = clearing_q;
    clr_cnt_d  = clr_cnt_q;
    if (clearing_q) begin
      clr_cnt_d = clr_cnt_q + AddrW'(1);
      if (clr_cnt_q == LastAddr) begin
        clearing_d = 1'b0;
        clr_cnt_d  = '0;
      end
    end else if (accept && cmd_e'(cmd_i) == CmdClear) begin
      clearing_d = 1'b1;
      clr_cnt_d  = '0;
    end
  end

  assign fwd_d = accept && upd_we && (in_addr == s1_addr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q       <= 1'b0;
      fwd_q          <= 1'b0;
      clearing_q     <= 1'b1;
      clr_cnt_q      <= '0;
      result_valid_q <= 1'b0;
    end else begin
      s1_vld_q       <= accept;
      fwd_q          <= fwd_d;
      clearing_q     <= clearing_d;
      clr_cnt_q      <= clr_cnt_d;
      result_valid_q <= rd_go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q    <= cmd_e'(cmd_i);
      s1_row_q    <= row_index_i;
      s1_addr_q   <= in_addr;
      s1_col_ok_q <= in_col_ok;
      s1_row_ok_q <= in_row_ok;
      s1_bit_q    <= edge_bit_i;
      fwd_sig_q   <= new_sig;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_we) begin
      sig_mem[s1_addr_q] <= new_sig;
    end
    if (accept) begin
      rd_sig_q <= sig_mem[in_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      vld_mem[clr_cnt_q] <= 1'b0;
    end else if (upd_we) begin
      vld_mem[s1_addr_q] <= 1'b1;
    end
    if (accept) begin
      rd_vld_q <= vld_mem[in_addr];
    end
  end

  assign eff_vld = fwd_q || rd_vld_q;
  assign eff_sig = fwd_q ? fwd_sig_q : rd_sig_q;
  assign upd_we  = s1_vld_q && (s1_cmd_q == CmdUpdate) && s1_bit_q
                   && s1_col_ok_q && s1_row_ok_q;
  assign rd_go   = s1_vld_q && (s1_cmd_q == CmdRead);
  assign seen    = s1_col_ok_q && eff_vld;

  for (genvar k = 0; k < HwHashes; k++) begin : g_lane
    if (k < ActiveHashes) begin : g_act
      logic [CfgDataW+RowW-1:0] prod;
      logic [SigW-1:0]          hash;

      assign prod       = (CfgDataW+RowW)'(slope_q[k]) * (CfgDataW+RowW)'(s1_row_q);
      assign hash       = SigW'(offset_q[k]) + SigW'(prod);
      assign new_sig[k] = (!eff_vld || hash < eff_sig[k]) ? hash : eff_sig[k];
      assign out_sig[k] = seen ? eff_sig[k] : SigEmpty;
    end else begin : g_idle
      assign out_sig[k] = SigEmpty;
    end

    mhs_bucket u_bucket (
      .sig_i    (out_sig[k]),
      .bucket_o (out_bucket[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (rd_go) begin
      for (int k = 0; k < HwHashes; k++) begin
        res_sig_q[k]    <= out_sig[k];
        res_bucket_q[k] <= out_bucket[k];
      end
      res_seen_q <= seen;
    end
  end

  assign result_valid_o  = result_valid_q;
  assign sig_first_o     = res_sig_q[0];
  assign sig_second_o    = res_sig_q[1];
  assign sig_third_o     = res_sig_q[2];
  assign bucket_first_o  = res_bucket_q[0];
  assign bucket_second_o = res_bucket_q[1];
  assign bucket_third_o  = res_bucket_q[2];
  assign column_seen_o   = res_seen_q;

  a_unseen_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !column_seen_o) |->
      (sig_first_o == SigEmpty && sig_second_o == SigEmpty && sig_third_o == SigEmpty))
    else $error("unseen column reported a signature");

  a_bucket_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      (bucket_first_o < 4'd10 && bucket_second_o < 4'd10 && bucket_third_o < 4'd10))
    else $error("bucket out of range");

  a_fwd_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> $past(upd_we))
    else $error("forward taken without a preceding update write");

  a_sweep_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !upd_we)
    else $error("update write during clear sweep");

endmodule

`default_nettype wire

@@ verif/minhash_signature_engine_tb.sv @@
`timescale 1ns / 1ps

module minhash_signature_engine_tb;
  import mhs_pkg::*;

  localparam logic [CmdW-1:0] CmdUnused = 2'd3;
  localparam int NodeCount   = DefMaxNodes;
  localparam int SettleCycles = 6;
  localparam int StallLimit   = 8000;
  localparam int RandomPhases = 6;
  localparam int PhaseItems   = 95;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            edge_bit;
  } mh_item_t;

  typedef struct packed {
    logic [HwHashes-1:0][SigW-1:0]    sig;
    logic [HwHashes-1:0][BucketW-1:0] bucket;
    logic                             seen;
  } sig_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CmdW-1:0] cmd_i = CmdUpdate;
  logic [RowW-1:0] row_index_i = '0;
  logic [ColW-1:0] column_index_i = '0;
  logic edge_bit_i = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = CfgHash0Offset;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic result_valid_o;
  logic [SigW-1:0] sig_first_o, sig_second_o, sig_third_o;
  logic [BucketW-1:0] bucket_first_o, bucket_second_o, bucket_third_o;
  logic column_seen_o;

  minhash_signature_engine u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .row_index_i    (row_index_i),
    .column_index_i (column_index_i),
    .edge_bit_i     (edge_bit_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .sig_first_o    (sig_first_o),
    .sig_second_o   (sig_second_o),
    .sig_third_o    (sig_third_o),
    .bucket_first_o (bucket_first_o),
    .bucket_second_o(bucket_second_o),
    .bucket_third_o (bucket_third_o),
    .column_seen_o  (column_seen_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  mh_item_t    cmd_pending_q[$];
  sig_result_t sig_expect_q[$];

  logic [CfgDataW-1:0] hash_offset_m [HwHashes];
  logic [CfgDataW-1:0] hash_slope_m  [HwHashes];
  logic [SigW-1:0]     sig_mem       [HwHashes][NodeCount];
  logic                col_seen_m    [NodeCount];

  int  n_fail = 0;
  int  n_accepted = 0;
  int  n_reads = 0;
  int  n_clears = 0;
  int  n_settings = 0;
  int  gap_left = 0;
  int  stall_cycles = 0;
  bit  idle_en = 1'b1;
  mh_item_t    next_item;
  sig_result_t got_res;
  sig_result_t exp_res;

  task automatic apply_transaction(input logic [CmdW-1:0] cmd, input logic [RowW-1:0] row,
                                   input logic [ColW-1:0] col, input logic bitv);
    sig_result_t res;
    logic [SigW-1:0] h;
    case (cmd)
      CmdUpdate: begin
        if (bitv) begin
          for (int k = 0; k < HwHashes; k++) begin
            h = SigW'(hash_offset_m[k]) + SigW'(hash_slope_m[k]) * SigW'(row);
            if (!col_seen_m[col] || h < sig_mem[k][col]) sig_mem[k][col] = h;
          end
          col_seen_m[col] = 1'b1;
        end
      end
      CmdRead: begin
        res.seen = col_seen_m[col];
        for (int k = 0; k < HwHashes; k++) begin
          res.sig[k] = res.seen ? sig_mem[k][col] : SigEmpty;
          res.bucket[k] = BucketW'(res.sig[k] % 10);
        end
        sig_expect_q.push_back(res);
      end
      CmdClear: begin
        for (int c = 0; c < NodeCount; c++) col_seen_m[c] = 1'b0;
        n_clears++;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      n_fail++;
    end
  endtask

  task automatic push_item(input logic [CmdW-1:0] cmd, input int row, input int col,
                           input logic bitv);
    mh_item_t it;
    it.cmd = cmd;
    it.row = RowW'(row);
    it.col = ColW'(col);
    it.edge_bit = bitv;
    cmd_pending_q.push_back(it);
  endtask

  function automatic int pick_row();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 1023 : 0;
    return $urandom_range(0, 1023);
  endfunction

  task automatic queue_random_items(input int count);
    int hot [8];
    int sel;
    int burst;
    int col;
    int made;
    for (int i = 0; i < 8; i++) hot[i] = $urandom_range(0, 1023);
    hot[0] = 0;
    hot[7] = 1023;
    made = 0;
    while (made < count) begin
      sel = $urandom_range(0, 99);
      col = ($urandom_range(0, 3) != 0) ? hot[$urandom_range(0, 7)] : $urandom_range(0, 1023);
      if (sel < 2) begin
        push_item(CmdClear, $urandom_range(0, 1023), $urandom_range(0, 1023), 1'($urandom));
        made++;
      end else if (sel < 4) begin
        push_item(CmdUnused, $urandom_range(0, 1023), $urandom_range(0, 1023), 1'($urandom));
      end else if (sel < 26) begin
        burst = $urandom_range(2, 5);
        repeat (burst) push_item(CmdUpdate, pick_row(), col, 1'b1);
        push_item(CmdRead, $urandom_range(0, 1023), col, 1'($urandom));
        made += burst + 1;
      end else if (sel < 60) begin
        push_item(CmdUpdate, pick_row(), col, $urandom_range(0, 6) != 0);
        made++;
      end else begin
        push_item(CmdRead, $urandom_range(0, 1023), col, 1'($urandom));
        made++;
      end
    end
  endtask

  task automatic wait_quiet();
    while (cmd_pending_q.size() != 0 || start || sig_expect_q.size() != 0 || busy !== 1'b0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic load_hash_coeffs(input int phase);
    logic [CfgDataW-1:0] v;
    for (int i = 0; i < 2 * HwHashes; i++) begin
      case (phase)
        1: v = 4'd0;
        2: v = 4'd15;
        3: v = CfgDataW'($urandom_range(1, 10));
        4: v = CfgDataW'($urandom_range(0, 15));
        5: v = (i % 2 == 0) ? 4'd10 : 4'd1;
        default: v = (i % 2 == 0) ? 4'd1 : 4'd10;
      endcase
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_index_i <= cfg_idx_e'(i);
      cfg_wdata_i <= v;
      if (i % 2 == 0) hash_offset_m[i / 2] = v;
      else hash_slope_m[i / 2] = v;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_transaction(cmd_i, row_index_i, column_index_i, edge_bit_i);
        n_accepted++;
      end
      if (!start || !busy) begin
        if (gap_left != 0) begin
          start <= 1'b0;
          gap_left--;
        end else if (idle_en && $urandom_range(0, 15) == 0) begin
          start <= 1'b0;
          gap_left = $urandom_range(0, 10);
        end else if (cmd_pending_q.size() != 0) begin
          next_item = cmd_pending_q.pop_front();
          start <= 1'b1;
          cmd_i <= next_item.cmd;
          row_index_i <= next_item.row;
          column_index_i <= next_item.col;
          edge_bit_i <= next_item.edge_bit;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      got_res.sig = {sig_third_o, sig_second_o, sig_first_o};
      got_res.bucket = {bucket_third_o, bucket_second_o, bucket_first_o};
      got_res.seen = column_seen_o;
      if (sig_expect_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual sig %0d/%0d/%0d", $time,
                 sig_first_o, sig_second_o, sig_third_o);
        n_fail++;
      end else begin
        exp_res = sig_expect_q.pop_front();
        n_reads++;
        check_field("sig_first", exp_res.sig[0], got_res.sig[0]);
        check_field("sig_second", exp_res.sig[1], got_res.sig[1]);
        check_field("sig_third", exp_res.sig[2], got_res.sig[2]);
        check_field("bucket_first", exp_res.bucket[0], got_res.bucket[0]);
        check_field("bucket_second", exp_res.bucket[1], got_res.bucket[1]);
        check_field("bucket_third", exp_res.bucket[2], got_res.bucket[2]);
        check_field("column_seen", exp_res.seen, got_res.seen);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || cfg_we_i) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
      $display("[minhash_signature_engine] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    for (int k = 0; k < HwHashes; k++) begin
      hash_offset_m[k] = OffsetReset[k];
      hash_slope_m[k] = SlopeReset[k];
    end
    for (int c = 0; c < NodeCount; c++) begin
      col_seen_m[c] = 1'b0;
      for (int k = 0; k < HwHashes; k++) sig_mem[k][c] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_item(CmdRead, 0, 0, 1'b0);
    push_item(CmdRead, 1023, 1023, 1'b1);
    push_item(CmdUpdate, 0, 0, 1'b1);
    push_item(CmdRead, 0, 0, 1'b0);
    push_item(CmdUpdate, 1023, 1023, 1'b1);
    push_item(CmdRead, 0, 1023, 1'b0);
    push_item(CmdUpdate, 500, 0, 1'b0);
    push_item(CmdUpdate, 0, 1023, 1'b1);
    push_item(CmdUpdate, 1023, 0, 1'b1);
    push_item(CmdRead, 0, 1023, 1'b0);
    push_item(CmdRead, 0, 0, 1'b0);
    push_item(CmdUnused, 1023, 0, 1'b1);
    push_item(CmdUpdate, 900, 5, 1'b1);
    push_item(CmdUpdate, 10, 5, 1'b1);
    push_item(CmdUpdate, 700, 5, 1'b1);
    push_item(CmdRead, 0, 5, 1'b0);
    push_item(CmdClear, 0, 0, 1'b0);
    push_item(CmdRead, 0, 0, 1'b0);
    push_item(CmdRead, 0, 5, 1'b1);
    push_item(CmdUpdate, 1000, 0, 1'b1);
    push_item(CmdRead, 0, 0, 1'b0);
    push_item(CmdUpdate, 600, 7, 1'b1);
    push_item(CmdUpdate, 3, 7, 1'b0);
    push_item(CmdRead, 0, 7, 1'b0);
    queue_random_items(PhaseItems);
    wait_quiet();

    for (int p = 1; p <= RandomPhases; p++) begin
      load_hash_coeffs(p);
      if (p == RandomPhases) idle_en = 1'b0;
      queue_random_items(PhaseItems);
      wait_quiet();
    end

    $display("%0d transactions accepted, %0d signature reads checked", n_accepted, n_reads);
    $display("%0d clears, %0d coefficient sets beyond reset", n_clears, n_settings);
    if (n_fail == 0) begin
      $display("[minhash_signature_engine] OK");
    end else begin
      $display("[minhash_signature_engine] ERROR");
    end
    $finish;
  end

endmodule

@@ minhash_signature_engine.f @@
src/mhs_pkg.sv
src/mhs_bucket.sv
src/minhash_signature_engine.sv
verif/minhash_signature_engine_tb.sv
